/* design/bobc_pkg.sv */
// Shared types, constants and helpers for the bracket order book checker.
`default_nettype none
package bobc_pkg;

  localparam int unsigned OrderSlotsDefault = 16;
  localparam int unsigned MaxResults        = 16;
  localparam logic [31:0] FeeRateReset      = 32'd2576980;

  localparam int unsigned InDataW  = 232;
  localparam int unsigned OutDataW = 200;
  localparam int unsigned SlotW    = 4;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_CLOSED = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OPEN,
    S_SCAN,
    S_CHK,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_M6,
    S_EMIT,
    S_FIN
  } state_e;

  // One stored order
  typedef struct packed {
    logic               is_long;
    logic [31:0]        open_time;
    logic [31:0]        entry_price;
    logic [31:0]        target;
    logic [31:0]        limit;
    logic [31:0]        amount;
    logic signed [63:0] profit;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    kind_e              kind;
    logic [SlotW-1:0]   slot;
    logic               side;
    logic               hit_target;
    logic [31:0]        open_time;
    logic [31:0]        close_time;
    logic [31:0]        exit_price;
    logic [31:0]        closed_amount;
    logic signed [63:0] net_profit;
  } result_t;

  // Clamp a wide signed sum to the signed 64-bit range
  function automatic logic signed [63:0] sat64(input logic signed [66:0] v);
    logic signed [66:0] hi_lim;
    logic signed [66:0] lo_lim;
    hi_lim = {4'b0000, {63{1'b1}}};
    lo_lim = {4'b1111, {63{1'b0}}};
    if (v > hi_lim) begin
      return {1'b0, {63{1'b1}}};
    end else if (v < lo_lim) begin
      return {1'b1, {63{1'b0}}};
    end else begin
      return v[63:0];
    end
  endfunction

endpackage
`default_nettype wire

/* design/bracket_order_book_checker_unit.sv */
// Bracket order book: order table in RAM, bar scan with one shared multiplier.
// Open item: the result follows the entry notional product, two fee partial products and fee sum;
// a rejected open skips these steps and goes straight to the emit state.
// Bar item: SCAN per free slot, SCAN, CHK per slot kept, SCAN, CHK, M1-M6, EMIT per close;
// each close is held until the next close is ready, the last one leaves at the end of the scan.
// Throughput is set by the single 32x32 multiplier and the one RAM port; one item at a time.
// Reset clears the valid bits and the control state at once; fee rate returns to 0.0006.
`default_nettype none
module bracket_order_book_checker_unit #(
  parameter int unsigned ORDER_SLOTS = bobc_pkg::OrderSlotsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [31:0]                   cfg_wdata_i,   // fee_rate
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // direction, timestamp, entry_price, take_profit, stop_loss, quantity, bar_high, bar_low
  input  wire logic [bobc_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  wire logic                          s_axis_tuser_i, // opcode
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // slot, side, hit_target, open_time, close_time, exit_price, closed_amount, net_profit
  output logic [bobc_pkg::OutDataW-1:0]      m_axis_tdata_o,
  output logic [1:0]                         m_axis_tuser_o, // kind
  output logic                               m_axis_tlast_o
);

  localparam int unsigned IdxW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(bobc_pkg::MaxResults + 1);

  bobc_pkg::state_e state_q, state_d;

  logic [IdxW:0]        idx_q, idx_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [ORDER_SLOTS-1:0] valid_q, valid_d;
  logic [31:0]          fee_q;
  logic                 open_q, open_d, full_q, full_d, dir_q, dir_d;
  logic [31:0]          ts_q, ts_d, entry_q, entry_d, tp_q, tp_d, sl_q, sl_d;
  logic [31:0]          qty_q, qty_d, hi_q, hi_d, lo_q, lo_d;
  bobc_pkg::entry_t     ent_q, ent_d;
  logic [31:0]          px_q, px_d;
  logic                 hit_q, hit_d;
  logic [63:0]          mul_q;
  logic [31:0]          mul_a, mul_b;
  logic [31:0]          ph_q, ph_d;
  logic [32:0]          frac_q, frac_d;
  logic [64:0]          feev_q, feev_d;
  logic signed [63:0]   acc_q, acc_d;
  logic                 pend_q, pend_d;
  bobc_pkg::result_t    pend_res_q, pend_res_d;
  logic                 out_valid_q, out_valid_d, out_last_q, out_last_d;
  bobc_pkg::result_t    out_res_q, out_res_d;

  logic                 ram_we;
  bobc_pkg::entry_t     ram_wdata, ram_rdata;
  logic [IdxW-1:0]      ram_addr;

  logic                 accept, out_free, full, closed, chk_hit, gain;
  logic [IdxW-1:0]      free_idx;
  logic [31:0]          chk_px, diff;
  bobc_pkg::result_t    new_res;
  logic [IdxW-1:0]      cur;

  assign cur      = idx_q[IdxW-1:0];
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign full     = &valid_q;

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  // Stop-loss first, then target
  always_comb begin
    closed  = 1'b0;
    chk_hit = 1'b0;
    chk_px  = '0;
    if (ram_rdata.is_long) begin
      if (lo_q <= ram_rdata.limit) begin
        closed = 1'b1;
        chk_px = ram_rdata.limit;
      end else if (hi_q >= ram_rdata.target) begin
        closed  = 1'b1;
        chk_hit = 1'b1;
        chk_px  = ram_rdata.target;
      end
    end else begin
      if (hi_q >= ram_rdata.limit) begin
        closed = 1'b1;
        chk_px = ram_rdata.limit;
      end else if (lo_q <= ram_rdata.target) begin
        closed  = 1'b1;
        chk_hit = 1'b1;
        chk_px  = ram_rdata.target;
      end
    end
  end

  assign diff = (px_q >= ent_q.entry_price) ? px_q - ent_q.entry_price
                                            : ent_q.entry_price - px_q;
  assign gain = ((px_q >= ent_q.entry_price) == ent_q.is_long) ||
                (px_q == ent_q.entry_price);

  always_comb begin
    new_res = '0;
    new_res.side      = dir_q;
    new_res.open_time = ts_q;
    if (!open_q) begin
      new_res.kind          = bobc_pkg::KIND_CLOSED;
      new_res.slot          = bobc_pkg::SlotW'(idx_q);
      new_res.side          = ent_q.is_long;
      new_res.hit_target    = hit_q;
      new_res.open_time     = ent_q.open_time;
      new_res.close_time    = ts_q;
      new_res.exit_price    = px_q;
      new_res.closed_amount = ent_q.amount;
      new_res.net_profit    = acc_q;
    end else if (full_q) begin
      new_res.kind = bobc_pkg::KIND_REJECT;
    end else begin
      new_res.kind       = bobc_pkg::KIND_ACCEPT;
      new_res.slot       = bobc_pkg::SlotW'(idx_q);
      new_res.net_profit = acc_q;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bobc_pkg::S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser_i) begin
            state_d = bobc_pkg::S_SCAN;
          end else if (full) begin
            state_d = bobc_pkg::S_EMIT;
          end else begin
            state_d = bobc_pkg::S_OPEN;
          end
        end
      end
      bobc_pkg::S_OPEN: state_d = bobc_pkg::S_M3;
      bobc_pkg::S_SCAN: begin
        if (idx_q == (IdxW + 1)'(ORDER_SLOTS)) begin
          state_d = bobc_pkg::S_FIN;
        end else if (valid_q[cur]) begin
          state_d = bobc_pkg::S_CHK;
        end
      end
      bobc_pkg::S_CHK: state_d = closed ? bobc_pkg::S_M1 : bobc_pkg::S_SCAN;
      bobc_pkg::S_M1:  state_d = bobc_pkg::S_M2;
      bobc_pkg::S_M2:  state_d = bobc_pkg::S_M3;
      bobc_pkg::S_M3:  state_d = bobc_pkg::S_M4;
      bobc_pkg::S_M4:  state_d = bobc_pkg::S_M5;
      bobc_pkg::S_M5:  state_d = bobc_pkg::S_M6;
      bobc_pkg::S_M6:  state_d = bobc_pkg::S_EMIT;
      bobc_pkg::S_EMIT: begin
        if (open_q) begin
          if (out_free) begin
            state_d = bobc_pkg::S_IDLE;
          end
        end else if (!pend_q || out_free) begin
          state_d = (cnt_q == CntW'(bobc_pkg::MaxResults - 1)) ? bobc_pkg::S_FIN
                                                               : bobc_pkg::S_SCAN;
        end
      end
      bobc_pkg::S_FIN: begin
        if (!pend_q || out_free) begin
          state_d = bobc_pkg::S_IDLE;
        end
      end
      default: state_d = bobc_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    valid_d    = valid_q;
    open_d     = open_q;
    full_d     = full_q;
    dir_d      = dir_q;
    ts_d       = ts_q;
    entry_d    = entry_q;
    tp_d       = tp_q;
    sl_d       = sl_q;
    qty_d      = qty_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    ent_d      = ent_q;
    px_d       = px_q;
    hit_d      = hit_q;
    ph_d       = ph_q;
    frac_d     = frac_q;
    feev_d     = feev_q;
    acc_d      = acc_q;
    pend_d     = pend_q;
    pend_res_d = pend_res_q;
    out_res_d  = out_res_q;
    out_last_d = out_last_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    mul_a      = '0;
    mul_b      = '0;
    ram_we     = 1'b0;
    ram_addr   = cur;
    ram_wdata  = '{is_long: dir_q, open_time: ts_q, entry_price: entry_q, target: tp_q,
                   limit: sl_q, amount: qty_q, profit: acc_q};
    unique case (state_q)
      bobc_pkg::S_IDLE: begin
        if (accept) begin
          open_d  = !s_axis_tuser_i;
          full_d  = full;
          dir_d   = s_axis_tdata_i[0];
          ts_d    = s_axis_tdata_i[32:1];
          entry_d = s_axis_tdata_i[64:33];
          tp_d    = s_axis_tdata_i[96:65];
          sl_d    = s_axis_tdata_i[128:97];
          qty_d   = s_axis_tdata_i[160:129];
          hi_d    = s_axis_tdata_i[192:161];
          lo_d    = s_axis_tdata_i[224:193];
          idx_d   = s_axis_tuser_i ? '0 : {1'b0, free_idx};
          cnt_d   = '0;
        end
      end
      bobc_pkg::S_OPEN: begin
        mul_a = entry_q;
        mul_b = qty_q;
        acc_d = '0;
      end
      bobc_pkg::S_SCAN: begin
        if (idx_q != (IdxW + 1)'(ORDER_SLOTS) && !valid_q[cur]) begin
          idx_d = idx_q + 1'b1;
        end
      end
      bobc_pkg::S_CHK: begin
        ent_d = ram_rdata;
        px_d  = chk_px;
        hit_d = chk_hit;
        acc_d = ram_rdata.profit;
        if (!closed) begin
          idx_d = idx_q + 1'b1;
        end
      end
      bobc_pkg::S_M1: begin
        mul_a = diff;
        mul_b = ent_q.amount;
      end
      bobc_pkg::S_M2: begin
        // gross result, then exit notional
        if (gain) begin
          acc_d = bobc_pkg::sat64({{3{acc_q[63]}}, acc_q} + {3'b000, mul_q});
        end else begin
          acc_d = bobc_pkg::sat64({{3{acc_q[63]}}, acc_q} - {3'b000, mul_q});
        end
        mul_a = px_q;
        mul_b = ent_q.amount;
      end
      bobc_pkg::S_M3: begin
        ph_d  = mul_q[63:32];
        mul_a = mul_q[31:0];
        mul_b = fee_q;
      end
      bobc_pkg::S_M4: begin
        frac_d = 33'(({1'b0, mul_q} + 65'h0_8000_0000) >> 32);
        mul_a  = ph_q;
        mul_b  = fee_q;
      end
      bobc_pkg::S_M5: begin
        feev_d = {1'b0, mul_q} + {32'd0, frac_q};
      end
      bobc_pkg::S_M6: begin
        acc_d = bobc_pkg::sat64({{3{acc_q[63]}}, acc_q} - {2'b00, feev_q});
      end
      bobc_pkg::S_EMIT: begin
        if (open_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_res_d   = new_res;
            out_last_d  = 1'b1;
            if (!full_q) begin
              ram_we        = 1'b1;
              valid_d[cur]  = 1'b1;
            end
          end
        end else if (!pend_q || out_free) begin
          // hold each close until the next one shows whether it is the last
          if (pend_q) begin
            out_valid_d = 1'b1;
            out_res_d   = pend_res_q;
            out_last_d  = 1'b0;
          end
          pend_d       = 1'b1;
          pend_res_d   = new_res;
          valid_d[cur] = 1'b0;
          idx_d        = idx_q + 1'b1;
          cnt_d        = cnt_q + 1'b1;
        end
      end
      bobc_pkg::S_FIN: begin
        if (pend_q && out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = pend_res_q;
          out_last_d  = 1'b1;
          pend_d      = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bobc_pkg::S_IDLE;
      valid_q     <= '0;
      fee_q       <= bobc_pkg::FeeRateReset;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        fee_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    open_q     <= open_d;
    full_q     <= full_d;
    dir_q      <= dir_d;
    ts_q       <= ts_d;
    entry_q    <= entry_d;
    tp_q       <= tp_d;
    sl_q       <= sl_d;
    qty_q      <= qty_d;
    hi_q       <= hi_d;
    lo_q       <= lo_d;
    ent_q      <= ent_d;
    px_q       <= px_d;
    hit_q      <= hit_d;
    mul_q      <= 64'(mul_a) * 64'(mul_b);
    ph_q       <= ph_d;
    frac_q     <= frac_d;
    feev_q     <= feev_d;
    acc_q      <= acc_d;
    pend_res_q <= pend_res_d;
    out_res_q  <= out_res_d;
    out_last_q <= out_last_d;
  end

  bobc_ram #(
    .WIDTH(bobc_pkg::EntryW),
    .DEPTH(ORDER_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready_o = (state_q == bobc_pkg::S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.kind;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {2'b00, out_res_q.net_profit, out_res_q.closed_amount,
                            out_res_q.exit_price, out_res_q.close_time,
                            out_res_q.open_time, out_res_q.hit_target,
                            out_res_q.side, out_res_q.slot};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(bobc_pkg::MaxResults))
    else $error("close count beyond result limit");

  a_no_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bobc_pkg::S_IDLE |-> !pend_q)
    else $error("held close left behind at idle");

  a_chk_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bobc_pkg::S_CHK |-> valid_q[cur])
    else $error("checking a free slot");

  a_close_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bobc_pkg::S_EMIT && !open_q && (!pend_q || out_free))
      |=> !valid_q[$past(cur)])
    else $error("closed slot still valid");

endmodule
`default_nettype wire

/* design/bobc_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module bobc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire
